@@ hdl/dsr_pkg.sv @@
// Shared types, codes and helper functions of the dock sequencer.
package dsr_pkg;

    localparam int TIMER_BITS = 17;
    localparam int CMP_BITS   = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    typedef logic [TIMER_BITS-1:0] timer_t;
    localparam timer_t TIMER_MAX = '1;

    typedef enum logic [3:0] {
        ST_UNKNOWN    = 4'd0,
        ST_DOCKED     = 4'd1,
        ST_UNDOCKED   = 4'd2,
        ST_UNDOCK_M1  = 4'd3,
        ST_UNDOCK_M2  = 4'd4,
        ST_DOCK_M2    = 4'd5,
        ST_DOCK_M1    = 4'd6,
        ST_PROP_OPEN  = 4'd7,
        ST_PROP_CLOSE = 4'd8,
        ST_TESTING    = 4'd9,
        ST_ERROR      = 4'd10,
        ST_BOOT_CLOSE = 4'd11
    } seq_state_t;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_UNDOCK = 3'd1;
    localparam logic [2:0] OP_DOCK   = 3'd2;
    localparam logic [2:0] OP_JOG    = 3'd3;
    localparam logic [2:0] OP_RESET  = 3'd4;
    localparam logic [2:0] OP_BOOT   = 3'd5;

    localparam logic [1:0] DRV_STOP = 2'd0;
    localparam logic [1:0] DRV_FWD  = 2'd1;
    localparam logic [1:0] DRV_REV  = 2'd2;
    localparam logic [1:0] DRV_JOG  = 2'd3;

    localparam logic [1:0] MOTOR_M1   = 2'd0;
    localparam logic [1:0] MOTOR_M2   = 2'd1;
    localparam logic [1:0] MOTOR_PROP = 2'd2;

    localparam logic [1:0] JOG_NONE = 2'd0;

    localparam logic [2:0] CFG_STAGE_TIMEOUT    = 3'd0;
    localparam logic [2:0] CFG_MAX_RETRIES      = 3'd1;
    localparam logic [2:0] CFG_RETRY_DELAY      = 3'd2;
    localparam logic [2:0] CFG_RECHECK_INTERVAL = 3'd3;
    localparam logic [2:0] CFG_JOG_DURATION     = 3'd4;

    typedef struct packed {
        logic [15:0] stage_timeout;
        logic [3:0]  max_retries;
        logic [15:0] retry_delay;
        logic [15:0] recheck_interval;
        logic [15:0] jog_duration;
    } cfg_t;

    typedef struct packed {
        seq_state_t      seq;
        seq_state_t      reported;
        timer_t          stage_el;
        logic [4:0]      retries;
        logic            pending;
        timer_t          wait_el;
        timer_t          rest_el;
        timer_t          jog_el;
        logic [1:0]      jog_tgt;
        logic [2:0][1:0] drive;
    } ctx_t;

    typedef struct packed {
        seq_state_t      state_code;
        logic [2:0][1:0] drive;
        logic            rejected;
        logic            changed;
        logic [4:0]      retry_count;
    } res_t;

    function automatic timer_t bump(input timer_t c);
        return (c == TIMER_MAX) ? c : timer_t'(c + 1'b1);
    endfunction

    function automatic logic at_least(input timer_t t, input logic [15:0] lim);
        return CMP_BITS'(t) >= CMP_BITS'(lim);
    endfunction

    function automatic logic is_busy(input seq_state_t s);
        return (s >= ST_UNDOCK_M1 && s <= ST_TESTING) || s == ST_BOOT_CLOSE;
    endfunction

    // Switch vector order: m1 undock, m1 dock, m2 undock, m2 dock, open, close.
    function automatic seq_state_t infer_rest(input logic [5:0] sw);
        logic docked;
        logic undocked;
        docked   = sw[1] & sw[3] & sw[5];
        undocked = sw[0] & sw[2];
        if (docked && !undocked) begin
            return ST_DOCKED;
        end
        if (undocked && !docked) begin
            return ST_UNDOCKED;
        end
        return ST_UNKNOWN;
    endfunction

    function automatic logic [1:0] stage_motor(input seq_state_t s);
        case (s)
            ST_UNDOCK_M1: return MOTOR_M1;
            ST_UNDOCK_M2: return MOTOR_M2;
            ST_DOCK_M2:   return MOTOR_M2;
            ST_DOCK_M1:   return MOTOR_M1;
            default:      return MOTOR_PROP;
        endcase
    endfunction

    function automatic logic [1:0] stage_dir(input seq_state_t s);
        case (s)
            ST_UNDOCK_M1: return DRV_FWD;
            ST_UNDOCK_M2: return DRV_FWD;
            ST_PROP_OPEN: return DRV_FWD;
            default:      return DRV_REV;
        endcase
    endfunction

endpackage

@@ hdl/dock_sequencer_with_stage_retry.sv @@
// Top level of the dock sequencer: state, configuration and result registers.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_ready       op, jog_motor, six limit switches
//   out      output     out_valid / out_ready     state_code, drives, flags, retry_count
//   cfg      input      cfg_we                    cfg_addr, cfg_wdata
//
// For every item, the sequencer state is updated in the cycle it is
// accepted, and its result appears in the output register on the next cycle.
// A new item is accepted every cycle while the output register is empty or is
// being emptied; a stalled output holds the input off for as long as it stalls.
// Reset clears the state, loads the register defaults and empties the output.
module dock_sequencer_with_stage_retry
    import dsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [1:0]  jog_motor,
    input  logic        m1_undock_hit,
    input  logic        m1_dock_hit,
    input  logic        m2_undock_hit,
    input  logic        m2_dock_hit,
    input  logic        prop_open_hit,
    input  logic        prop_close_hit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  state_code,
    output logic [1:0]  m1_drive,
    output logic [1:0]  m2_drive,
    output logic [1:0]  prop_drive,
    output logic        rejected,
    output logic        state_changed,
    output logic [4:0]  retry_count
);

    cfg_t       cfg_reg;
    ctx_t       ctx_reg;
    ctx_t       ctx_next;
    res_t       res_next;
    res_t       res_reg;
    logic       out_valid_reg;
    logic       accept;
    logic [5:0] sw;

    assign sw = {prop_close_hit, prop_open_hit, m2_dock_hit, m2_undock_hit,
                 m1_dock_hit, m1_undock_hit};

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    dsr_step u_step (
        .cur       (ctx_reg),
        .cfg       (cfg_reg),
        .op        (op),
        .jog_motor (jog_motor),
        .sw        (sw),
        .nxt       (ctx_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stage_timeout    <= 16'd10000;
            cfg_reg.max_retries      <= 4'd2;
            cfg_reg.retry_delay      <= 16'd1000;
            cfg_reg.recheck_interval <= 16'd1000;
            cfg_reg.jog_duration     <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_STAGE_TIMEOUT:    cfg_reg.stage_timeout    <= cfg_wdata;
                CFG_MAX_RETRIES:      cfg_reg.max_retries      <= cfg_wdata[3:0];
                CFG_RETRY_DELAY:      cfg_reg.retry_delay      <= cfg_wdata;
                CFG_RECHECK_INTERVAL: cfg_reg.recheck_interval <= cfg_wdata;
                CFG_JOG_DURATION:     cfg_reg.jog_duration     <= cfg_wdata;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= '0;
        end
        else if (accept)
        begin
            ctx_reg <= ctx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign state_code    = res_reg.state_code;
    assign m1_drive      = res_reg.drive[MOTOR_M1];
    assign m2_drive      = res_reg.drive[MOTOR_M2];
    assign prop_drive    = res_reg.drive[MOTOR_PROP];
    assign rejected      = res_reg.rejected;
    assign state_changed = res_reg.changed;
    assign retry_count   = res_reg.retry_count;

`ifndef SYNTH
    a_retries_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.retries <= 5'd16)
        else $error("Retry count beyond its bound.");

    a_testing_has_target: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.seq == ST_TESTING |-> ctx_reg.jog_tgt != JOG_NONE)
        else $error("Testing state without a jog target.");

    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_next.rejected |=> ctx_reg.seq == $past(ctx_reg.seq))
        else $error("A rejected item changed the state.");

    a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg && res_reg.state_code == ctx_reg.seq)
        else $error("Accepted item did not reach the output register.");
`endif

endmodule

@@ hdl/dsr_step.sv @@
// Next-state and result logic for one item of the dock sequencer.
module dsr_step
    import dsr_pkg::*;
(
    input  ctx_t       cur,
    input  cfg_t       cfg,
    input  logic [2:0] op,
    input  logic [1:0] jog_motor,
    input  logic [5:0] sw,
    output ctx_t       nxt,
    output res_t       res
);

    ctx_t       n;
    logic       rejected;
    logic       changed;
    seq_state_t fresh;
    logic [1:0] st_motor;
    logic [1:0] st_dir;
    logic       st_hit;
    logic [1:0] jog_idx;
    logic [1:0] jm_idx;

    assign fresh    = infer_rest(sw);
    assign st_motor = stage_motor(cur.seq);
    assign st_dir   = stage_dir(cur.seq);
    assign st_hit   = sw[{st_motor, st_dir == DRV_REV}];
    assign jog_idx  = 2'(cur.jog_tgt - 2'd1);
    assign jm_idx   = 2'(jog_motor - 2'd1);

    always_comb
    begin
        n        = cur;
        rejected = 1'b0;
        case (op)
            OP_TICK:
            begin
                n.stage_el = bump(cur.stage_el);
                n.wait_el  = bump(cur.wait_el);
                n.rest_el  = bump(cur.rest_el);
                n.jog_el   = bump(cur.jog_el);
                for (int k = 0; k < 3; k++)
                begin
                    if ((cur.drive[k] == DRV_FWD || cur.drive[k] == DRV_REV)
                        && sw[{2'(k), cur.drive[k] == DRV_REV}])
                    begin
                        n.drive[k] = DRV_STOP;
                    end
                end
                case (cur.seq)
                    ST_UNKNOWN, ST_DOCKED, ST_UNDOCKED, ST_ERROR:
                    begin
                        if (at_least(n.rest_el, cfg.recheck_interval))
                        begin
                            n.rest_el = '0;
                            if (fresh != cur.seq && (cur.seq != ST_ERROR || fresh != ST_UNKNOWN))
                            begin
                                n.seq = fresh;
                            end
                        end
                    end
                    ST_TESTING:
                    begin
                        if (at_least(n.jog_el, cfg.jog_duration))
                        begin
                            if (cur.jog_tgt != JOG_NONE)
                            begin
                                n.drive[jog_idx] = DRV_STOP;
                            end
                            n.jog_tgt = JOG_NONE;
                            n.seq     = fresh;
                        end
                    end
                    default:
                    begin
                        if (st_hit)
                        begin
                            case (cur.seq)
                                ST_UNDOCK_M1:
                                begin
                                    n.drive[MOTOR_M2] = DRV_FWD;
                                    n.seq      = ST_UNDOCK_M2;
                                    n.stage_el = '0;
                                    n.retries  = '0;
                                    n.pending  = 1'b0;
                                end
                                ST_UNDOCK_M2:
                                begin
                                    n.seq = ST_UNDOCKED;
                                end
                                ST_DOCK_M2:
                                begin
                                    n.drive[MOTOR_M1] = DRV_REV;
                                    n.seq      = ST_DOCK_M1;
                                    n.stage_el = '0;
                                    n.retries  = '0;
                                    n.pending  = 1'b0;
                                end
                                ST_DOCK_M1:
                                begin
                                    n.drive[MOTOR_PROP] = DRV_FWD;
                                    n.seq      = ST_PROP_OPEN;
                                    n.stage_el = '0;
                                    n.retries  = '0;
                                    n.pending  = 1'b0;
                                end
                                ST_PROP_OPEN:
                                begin
                                    n.drive[MOTOR_PROP] = DRV_REV;
                                    n.seq      = ST_PROP_CLOSE;
                                    n.stage_el = '0;
                                    n.retries  = '0;
                                    n.pending  = 1'b0;
                                end
                                ST_PROP_CLOSE:
                                begin
                                    n.seq = ST_DOCKED;
                                end
                                default:
                                begin
                                    n.seq      = fresh;
                                    n.reported = fresh;
                                end
                            endcase
                        end
                        else if (cur.pending)
                        begin
                            if (at_least(n.wait_el, cfg.retry_delay))
                            begin
                                n.pending         = 1'b0;
                                n.stage_el        = '0;
                                n.drive[st_motor] = st_dir;
                            end
                        end
                        else if (CMP_BITS'(n.stage_el) > CMP_BITS'(cfg.stage_timeout))
                        begin
                            n.drive[st_motor] = DRV_STOP;
                            n.retries         = 5'(cur.retries + 5'd1);
                            if (n.retries > {1'b0, cfg.max_retries})
                            begin
                                n.seq = ST_ERROR;
                                if (cur.seq == ST_BOOT_CLOSE)
                                begin
                                    n.reported = ST_ERROR;
                                end
                            end
                            else
                            begin
                                n.pending = 1'b1;
                                n.wait_el = '0;
                            end
                        end
                    end
                endcase
            end
            OP_UNDOCK:
            begin
                if (is_busy(cur.seq))
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    n.drive[MOTOR_M1] = DRV_FWD;
                    n.seq      = ST_UNDOCK_M1;
                    n.stage_el = '0;
                    n.retries  = '0;
                    n.pending  = 1'b0;
                end
            end
            OP_DOCK:
            begin
                if (is_busy(cur.seq))
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    n.drive[MOTOR_M2] = DRV_REV;
                    n.seq      = ST_DOCK_M2;
                    n.stage_el = '0;
                    n.retries  = '0;
                    n.pending  = 1'b0;
                end
            end
            OP_JOG:
            begin
                if (is_busy(cur.seq) || jog_motor == JOG_NONE)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    n.jog_tgt       = jog_motor;
                    n.jog_el        = '0;
                    n.seq           = ST_TESTING;
                    n.drive[jm_idx] = DRV_JOG;
                end
            end
            OP_RESET:
            begin
                n.drive   = '0;
                n.jog_tgt = JOG_NONE;
                n.pending = 1'b0;
                n.seq     = fresh;
            end
            OP_BOOT:
            begin
                if (is_busy(cur.seq))
                begin
                    rejected = 1'b1;
                end
                else if (!sw[5])
                begin
                    n.drive[MOTOR_PROP] = DRV_REV;
                    n.seq      = ST_BOOT_CLOSE;
                    n.stage_el = '0;
                    n.retries  = '0;
                    n.pending  = 1'b0;
                end
                else
                begin
                    n.seq      = fresh;
                    n.reported = fresh;
                end
            end
            default:
            begin
                n = cur;
            end
        endcase

        changed = (n.seq != n.reported);
        if (changed)
        begin
            n.reported = n.seq;
        end

        nxt             = n;
        res.state_code  = n.seq;
        res.drive       = n.drive;
        res.rejected    = rejected;
        res.changed     = changed;
        res.retry_count = n.retries;
    end

endmodule
